// ===== hw/rtl/scba_pkg.sv =====
// ----------------------------------------------------------------------------
// scba_pkg: shared definitions for the size-class block allocator
// Field widths, heap geometry, operation and status codes and the fixed
// size-class tables.
// ----------------------------------------------------------------------------
package scba_pkg;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int SIZE_W   = 32;
  localparam int ADDR_W   = 20;
  localparam int STATUS_W = 3;
  localparam int BYTES_W  = 12;
  localparam int CLASS_W  = 6;
  localparam int LIDX_W   = 9;

  // Heap geometry.
  localparam int NUM_CLASSES       = 42;
  localparam int POOL_REGION_BYTES = 16384;
  localparam int COMMIT_BYTES      = 4096;
  localparam int MAX_BLOCK_BYTES   = 2048;
  localparam int REGION_SHIFT      = $clog2(POOL_REGION_BYTES);
  localparam int OFFSET_W          = REGION_SHIFT + 1;
  localparam int NEED_W            = OFFSET_W + 1;
  localparam int COUNT_W           = 12;
  localparam int MAX_COMMIT        = (POOL_REGION_BYTES / COMMIT_BYTES) * COMMIT_BYTES;
  localparam int unsigned HEAP_SPAN  = NUM_CLASSES * POOL_REGION_BYTES;
  localparam int LINK_DEPTH        = HEAP_SPAN >> 3;
  localparam int LINK_AW           = $clog2(LINK_DEPTH);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_REALLOC = 2'd2;
  localparam logic [OP_W-1:0] OP_SIZE    = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_NEW       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_KEPT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_SMALL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd4;

  // Per-class bookkeeping entry.
  typedef struct packed {
    logic [OFFSET_W-1:0] next_off;
    logic [OFFSET_W-1:0] commit_off;
    logic [ADDR_W-1:0]   head;
    logic [COUNT_W-1:0]  count;
  } class_ent_t;

  // Class of a lookup index, index = (size - 1) >> 2.
  function automatic logic [CLASS_W-1:0] class_of_index(input logic [LIDX_W-1:0] i);
    logic [CLASS_W-1:0] c;
    if (i < 9'd32)       c = 6'(i[4:1]);
    else if (i < 9'd64)  c = 6'd16 + 6'(i[4:2]);
    else if (i < 9'd128) c = 6'd24 + 6'(i[5:3]);
    else if (i < 9'd192) c = 6'd32 + 6'(i[5:4]);
    else if (i < 9'd256) c = 6'd36 + 6'(i[5]);
    else                 c = 6'd38 + 6'(i[7:6]);
    return c;
  endfunction

  // Block bytes of each class.
  function automatic logic [BYTES_W-1:0] class_size(input logic [CLASS_W-1:0] c);
    logic [BYTES_W-1:0] s;
    case (c)
      6'd0:  s = 12'd8;    6'd1:  s = 12'd16;   6'd2:  s = 12'd24;   6'd3:  s = 12'd32;
      6'd4:  s = 12'd40;   6'd5:  s = 12'd48;   6'd6:  s = 12'd56;   6'd7:  s = 12'd64;
      6'd8:  s = 12'd72;   6'd9:  s = 12'd80;   6'd10: s = 12'd88;   6'd11: s = 12'd96;
      6'd12: s = 12'd104;  6'd13: s = 12'd112;  6'd14: s = 12'd120;  6'd15: s = 12'd128;
      6'd16: s = 12'd144;  6'd17: s = 12'd160;  6'd18: s = 12'd176;  6'd19: s = 12'd192;
      6'd20: s = 12'd208;  6'd21: s = 12'd224;  6'd22: s = 12'd240;  6'd23: s = 12'd256;
      6'd24: s = 12'd288;  6'd25: s = 12'd320;  6'd26: s = 12'd352;  6'd27: s = 12'd384;
      6'd28: s = 12'd416;  6'd29: s = 12'd448;  6'd30: s = 12'd480;  6'd31: s = 12'd512;
      6'd32: s = 12'd576;  6'd33: s = 12'd640;  6'd34: s = 12'd704;  6'd35: s = 12'd768;
      6'd36: s = 12'd896;  6'd37: s = 12'd1024; 6'd38: s = 12'd1280; 6'd39: s = 12'd1536;
      6'd40: s = 12'd1792; 6'd41: s = 12'd2048;
      default: s = 12'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/scba_req_if.sv =====
// ----------------------------------------------------------------------------
// scba_req_if: request channel
// Carries one allocator request item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface scba_req_if;
  logic                        valid;
  logic                        ready;
  logic [scba_pkg::OP_W-1:0]   operation;
  logic [scba_pkg::SIZE_W-1:0] size_bytes;
  logic [scba_pkg::ADDR_W-1:0] address;

  modport source (output valid, operation, size_bytes, address, input ready);
  modport sink   (input valid, operation, size_bytes, address, output ready);
endinterface

// ===== hw/rtl/scba_rsp_if.sv =====
// ----------------------------------------------------------------------------
// scba_rsp_if: response channel
// Carries one allocator result item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface scba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [scba_pkg::ADDR_W-1:0]   block_address;
  logic [scba_pkg::STATUS_W-1:0] status;
  logic [scba_pkg::BYTES_W-1:0]  block_size;
  logic [scba_pkg::BYTES_W-1:0]  copy_bytes;

  modport source (output valid, block_address, status, block_size, copy_bytes,
                  input ready);
  modport sink   (input valid, block_address, status, block_size, copy_bytes,
                  output ready);
endinterface

// ===== hw/rtl/scba_cfg_if.sv =====
// ----------------------------------------------------------------------------
// scba_cfg_if: configuration write channel
// Carries the heap enable register write with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface scba_cfg_if;
  logic valid;
  logic ready;
  logic heap_enable;

  modport source (output valid, heap_enable, input ready);
  modport sink   (input valid, heap_enable, output ready);
endinterface

// ===== hw/rtl/size_class_block_allocator_core.sv =====
// Sequence: get size and rejects go from accept straight to the result state; free
// and non-small reallocate pass the release state; allocate passes the grab state,
// a list pop then the pop state, and a moving reallocate also both release states.
// No request is accepted until the previous result is in the output register.
// Reset: class entries read as zero through 42 valid bits cleared at once; the
// free-link memory is not cleared. heap_enable resets to 1.
// ----------------------------------------------------------------------------
// size_class_block_allocator_core: segregated size-class block allocator
// Per-class bump pointers and LIFO free lists kept in a class memory, with
// list links in a block-indexed link memory.
// ----------------------------------------------------------------------------
module size_class_block_allocator_core (
  input  logic       clk,
  input  logic       rst,
  scba_req_if.sink   req,
  scba_rsp_if.source rsp,
  scba_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {
    S_IDLE, S_GRAB, S_POP, S_REL_RD, S_REL, S_OUT
  } state_t;

  localparam int CW = scba_pkg::CLASS_W;
  localparam int AW = scba_pkg::ADDR_W;
  localparam int BW = scba_pkg::BYTES_W;
  localparam int NW = scba_pkg::NEED_W;
  localparam int OW = scba_pkg::OFFSET_W;
  localparam logic [NW:0] COMMIT_MASK = (NW+1)'(scba_pkg::COMMIT_BYTES - 1);

  state_t state;
  logic   heap_enable;

  logic [scba_pkg::OP_W-1:0] op_r;
  logic [AW-1:0]             addr_r;
  logic [CW-1:0]             nc_r;
  logic [CW-1:0]             oc_r;
  scba_pkg::class_ent_t      cur;

  logic                          out_valid;
  logic [AW-1:0]                 res_addr;
  logic [scba_pkg::STATUS_W-1:0] res_status;
  logic [BW-1:0]                 res_size;
  logic [BW-1:0]                 res_copy;
  logic [AW-1:0]                 out_addr;
  logic [scba_pkg::STATUS_W-1:0] out_status;
  logic [BW-1:0]                 out_size;
  logic [BW-1:0]                 out_copy;

  // Class memory with per-entry valid bits, and the free-link memory.
  scba_pkg::class_ent_t cls_mem [scba_pkg::NUM_CLASSES];
  logic [scba_pkg::NUM_CLASSES-1:0] cls_valid;
  scba_pkg::class_ent_t cls_q;
  logic                 valid_q;
  logic [AW-1:0]        link_mem [scba_pkg::LINK_DEPTH];
  logic [AW-1:0]        link_q;

  logic [CW-1:0]                 cls_ra_raw;
  logic [CW-1:0]                 cls_ra;
  logic                          cls_we;
  logic [CW-1:0]                 cls_wa;
  scba_pkg::class_ent_t          cls_wd;
  logic [scba_pkg::LINK_AW-1:0]  link_ra;
  logic                          link_we;
  logic [scba_pkg::LINK_AW-1:0]  link_wa;
  logic [AW-1:0]                 link_wd;

  // Request decode.
  logic                   small_in;
  logic                   owned_in;
  logic [BW-1:0]          size_m1;
  logic [CW-1:0]          nc_in;
  logic [CW-1:0]          oc_in;
  logic [BW-1:0]          osz_in;
  logic [BW-1:0]          copy_in;

  // Grab arithmetic.
  scba_pkg::class_ent_t eff;
  logic [BW-1:0]        bs_nc;
  logic [NW-1:0]        need;
  logic [NW:0]          need_up;
  logic [OW-1:0]        commit_new;
  logic                 grab_ok;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid         = out_valid;
  assign rsp.block_address = out_addr;
  assign rsp.status        = out_status;
  assign rsp.block_size    = out_size;
  assign rsp.copy_bytes    = out_copy;

  // Decode of the incoming request.
  always_comb begin
    small_in = heap_enable && (req.size_bytes <= 32'(scba_pkg::MAX_BLOCK_BYTES));
    owned_in = heap_enable && (32'(req.address) < scba_pkg::HEAP_SPAN);
    size_m1  = (req.size_bytes == '0) ? '0 : (req.size_bytes[BW-1:0] - 12'd1);
    nc_in    = scba_pkg::class_of_index(size_m1[10:2]);
    oc_in    = req.address[AW-1:scba_pkg::REGION_SHIFT];
    osz_in   = scba_pkg::class_size(oc_in);
    if (req.size_bytes == '0) begin
      copy_in = 12'd1;
    end else if (req.size_bytes < 32'(osz_in)) begin
      copy_in = req.size_bytes[BW-1:0];
    end else begin
      copy_in = osz_in;
    end
  end

  // Memory addressing, grab arithmetic and write-back values.
  always_comb begin
    eff        = valid_q ? cls_q : '0;
    bs_nc      = scba_pkg::class_size(nc_r);
    need       = NW'(eff.next_off) + NW'(bs_nc);
    grab_ok    = (need <= NW'(scba_pkg::MAX_COMMIT));
    need_up    = (NW+1)'(need) + COMMIT_MASK;
    commit_new = (need > NW'(eff.commit_off)) ? OW'(need_up & ~COMMIT_MASK) : eff.commit_off;

    unique case (state)
      S_IDLE: begin
        cls_ra_raw = ((req.operation == scba_pkg::OP_FREE) ||
                      ((req.operation == scba_pkg::OP_REALLOC) && !small_in)) ? oc_in : nc_in;
      end
      S_REL_RD: cls_ra_raw = oc_r;
      default:  cls_ra_raw = nc_r;
    endcase
    cls_ra  = (cls_ra_raw < CW'(scba_pkg::NUM_CLASSES)) ? cls_ra_raw : '0;
    link_ra = eff.head[AW-1:3];

    cls_we  = 1'b0;
    cls_wa  = nc_r;
    cls_wd  = eff;
    link_we = 1'b0;
    link_wa = addr_r[AW-1:3];
    link_wd = eff.head;
    unique case (state)
      S_GRAB: begin
        if ((eff.count == '0) && grab_ok) begin
          cls_we = 1'b1;
          cls_wd = '{next_off: OW'(need), commit_off: commit_new,
                     head: eff.head, count: eff.count};
        end
      end
      S_POP: begin
        cls_we = 1'b1;
        cls_wd = '{next_off: cur.next_off, commit_off: cur.commit_off,
                   head: link_q, count: cur.count - 12'd1};
      end
      S_REL: begin
        cls_we  = 1'b1;
        cls_wa  = oc_r;
        cls_wd  = '{next_off: eff.next_off, commit_off: eff.commit_off,
                    head: addr_r, count: eff.count + 12'd1};
        link_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Class memory: at most one write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (cls_we) begin
      cls_mem[cls_wa] <= cls_wd;
    end
    cls_q <= cls_mem[cls_ra];
  end

  // Class entry valid bits, cleared together at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (cls_we) begin
        cls_valid[cls_wa] <= 1'b1;
      end
      valid_q <= cls_valid[cls_ra];
    end
  end

  // Free-link memory, indexed by block address in 8-byte units.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q <= link_mem[link_ra];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_enable <= 1'b1;
    end else if (cfg.valid) begin
      heap_enable <= cfg.heap_enable;
    end
  end

  // Request sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r       <= req.operation;
            addr_r     <= req.address;
            nc_r       <= nc_in;
            oc_r       <= oc_in;
            res_addr   <= '0;
            res_status <= scba_pkg::ST_NEW;
            res_size   <= '0;
            res_copy   <= '0;
            if (req.operation == scba_pkg::OP_ALLOC) begin
              if (small_in) begin
                state <= S_GRAB;
              end else begin
                res_status <= scba_pkg::ST_NOT_SMALL;
                state      <= S_OUT;
              end
            end else if (!owned_in) begin
              res_status <= scba_pkg::ST_NOT_OWNER;
              state      <= S_OUT;
            end else if (req.operation == scba_pkg::OP_SIZE) begin
              res_addr <= req.address;
              res_size <= osz_in;
              state    <= S_OUT;
            end else if (req.operation == scba_pkg::OP_FREE) begin
              res_addr <= req.address;
              res_size <= osz_in;
              state    <= S_REL;
            end else if (small_in && (nc_in == oc_in)) begin
              res_addr   <= req.address;
              res_size   <= osz_in;
              res_status <= scba_pkg::ST_KEPT;
              state      <= S_OUT;
            end else if (!small_in) begin
              res_status <= scba_pkg::ST_NOT_SMALL;
              res_copy   <= copy_in;
              state      <= S_REL;
            end else begin
              res_copy <= copy_in;
              state    <= S_GRAB;
            end
          end
        end
        S_GRAB: begin
          if (eff.count != '0) begin
            res_addr <= eff.head;
            res_size <= bs_nc;
            cur      <= eff;
            state    <= S_POP;
          end else begin
            if (grab_ok) begin
              res_addr <= {nc_r, eff.next_off[scba_pkg::REGION_SHIFT-1:0]};
              res_size <= bs_nc;
            end else begin
              res_status <= scba_pkg::ST_EXHAUSTED;
            end
            state <= (op_r == scba_pkg::OP_REALLOC) ? S_REL_RD : S_OUT;
          end
        end
        S_POP:    state <= (op_r == scba_pkg::OP_REALLOC) ? S_REL_RD : S_OUT;
        S_REL_RD: state <= S_REL;
        S_REL:    state <= S_OUT;
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_addr   <= res_addr;
            out_status <= res_status;
            out_size   <= res_size;
            out_copy   <= res_copy;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/scba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_checker: request/result checker for the size-class block allocator
// Watches the request, result and configuration channels, keeps its own copy
// of the allocator state, and compares every result item with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module scba_checker
  import scba_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  scba_req_if   req,
  scba_rsp_if   rsp,
  scba_cfg_if   cfg,
  output int    fail_count,
  output int    pending
);

  typedef struct {
    logic [ADDR_W-1:0]   addr;
    logic [STATUS_W-1:0] status;
    logic [BYTES_W-1:0]  size;
    logic [BYTES_W-1:0]  copy;
  } grant_t;

  grant_t grant_q[$];

  // Shadow allocator state.
  logic                heap_on;
  int unsigned         bump_off[NUM_CLASSES];
  int unsigned         limit_off[NUM_CLASSES];
  logic [ADDR_W-1:0]   list_head[NUM_CLASSES];
  logic [COUNT_W-1:0]  list_count[NUM_CLASSES];
  logic [ADDR_W-1:0]   next_link[int unsigned];
  logic [BYTES_W-1:0]  bytes_of_class[NUM_CLASSES];
  int unsigned         class_of_idx[MAX_BLOCK_BYTES / 4];

  // Build the class tables from the segment rule: step doubles each segment.
  initial begin
    int unsigned seg_end[6];
    int unsigned seg_step[6];
    int unsigned seg_per[6];
    int unsigned k, bytes, cls;
    seg_end  = '{32, 64, 128, 192, 256, 512};
    seg_step = '{8, 16, 32, 64, 128, 256};
    seg_per  = '{2, 4, 8, 16, 32, 64};
    k = 0;
    bytes = 0;
    cls = 0;
    for (int unsigned i = 0; i < MAX_BLOCK_BYTES / 4; i++) begin
      while (k < 5 && i >= seg_end[k]) k++;
      if (i % seg_per[k] == 0 && cls < NUM_CLASSES) begin
        bytes += seg_step[k];
        bytes_of_class[cls] = BYTES_W'(bytes);
        cls++;
      end
      class_of_idx[i] = (cls == 0) ? 0 : cls - 1;
    end
    fail_count = 0;
  end

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int unsigned size_class(input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] s;
    s = (sz == 0) ? 1 : sz;
    return class_of_idx[(s - 1) >> 2];
  endfunction

  // Take a block of class c from its free list or its bump pointer.
  function automatic bit take_block(input int unsigned c, output logic [ADDR_W-1:0] a);
    int unsigned bs;
    bs = bytes_of_class[c];
    a = '0;
    if (list_count[c] != 0) begin
      a = list_head[c];
      list_head[c] = next_link[a >> 3];
      list_count[c] = list_count[c] - 12'd1;
      return 1;
    end
    while (bump_off[c] + bs > limit_off[c]) begin
      if (limit_off[c] + COMMIT_BYTES > POOL_REGION_BYTES) return 0;
      limit_off[c] += COMMIT_BYTES;
    end
    a = ADDR_W'(c * POOL_REGION_BYTES + bump_off[c]);
    bump_off[c] += bs;
    return 1;
  endfunction

  function automatic void push_block(input logic [ADDR_W-1:0] a);
    int unsigned c;
    c = (a / POOL_REGION_BYTES) % NUM_CLASSES;
    next_link[a >> 3] = list_head[c];
    list_head[c] = a;
    list_count[c] = list_count[c] + 12'd1;
  endfunction

  // Work out the result of one request and advance the shadow state.
  function automatic grant_t serve_request(input logic [OP_W-1:0] op,
                                           input logic [SIZE_W-1:0] sz,
                                           input logic [ADDR_W-1:0] addr);
    grant_t g;
    bit is_small;
    int unsigned nc, oc;
    logic [BYTES_W-1:0] osz;
    logic [SIZE_W-1:0] want;
    logic [ADDR_W-1:0] a;
    g = '{'0, ST_NEW, '0, '0};
    is_small = heap_on && sz <= MAX_BLOCK_BYTES;
    if (op == OP_ALLOC) begin
      if (!is_small) g.status = ST_NOT_SMALL;
      else begin
        nc = size_class(sz);
        if (take_block(nc, a)) begin
          g.addr = a;
          g.size = bytes_of_class[nc];
        end else g.status = ST_EXHAUSTED;
      end
    end else if (!heap_on || addr >= HEAP_SPAN) begin
      g.status = ST_NOT_OWNER;
    end else begin
      oc = (addr / POOL_REGION_BYTES) % NUM_CLASSES;
      osz = bytes_of_class[oc];
      if (op == OP_FREE) begin
        push_block(addr);
        g.addr = addr;
        g.size = osz;
      end else if (op == OP_SIZE) begin
        g.addr = addr;
        g.size = osz;
      end else begin
        nc = is_small ? size_class(sz) : NUM_CLASSES;
        if (nc == oc) begin
          g.addr = addr;
          g.status = ST_KEPT;
          g.size = osz;
        end else begin
          want = (sz == 0) ? 1 : ((sz < osz) ? sz : SIZE_W'(osz));
          g.copy = BYTES_W'(want);
          if (nc >= NUM_CLASSES) g.status = ST_NOT_SMALL;
          else if (take_block(nc, a)) begin
            g.addr = a;
            g.size = bytes_of_class[nc];
          end else g.status = ST_EXHAUSTED;
          push_block(addr);
        end
      end
    end
    return g;
  endfunction

  // Follow the three channels at each rising edge.
  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      heap_on = 1'b1;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        bump_off[c] = 0;
        limit_off[c] = 0;
        list_head[c] = '0;
        list_count[c] = '0;
      end
      grant_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) heap_on = cfg.heap_enable;
      if (req.valid && req.ready)
        grant_q.push_back(serve_request(req.operation, req.size_bytes, req.address));
      if (rsp.valid && rsp.ready) begin
        if (grant_q.size() == 0) begin
          $display("%0t mismatch: result item with nothing expected", $time);
          fail_count++;
        end else begin
          g = grant_q.pop_front();
          if (rsp.block_address !== g.addr) report("block_address", rsp.block_address, g.addr);
          if (rsp.status !== g.status) report("status", rsp.status, g.status);
          if (rsp.block_size !== g.size) report("block_size", rsp.block_size, g.size);
          if (rsp.copy_bytes !== g.copy) report("copy_bytes", rsp.copy_bytes, g.copy);
        end
      end
    end
    pending = grant_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the size-class block allocator
// Drives directed corner requests, a disabled-heap stretch and three random
// phases with varying sender and receiver idling; a checker scores results.
// ----------------------------------------------------------------------------
module testbench;
  import scba_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 138;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles;
  int   sent;
  int   tx_idle_pct;
  int   rx_stall_pct;
  logic hold_rx;

  logic [OP_W-1:0]   sent_ops[$];
  logic [ADDR_W-1:0] live_blocks[$];

  scba_req_if req ();
  scba_rsp_if rsp ();
  scba_cfg_if cfg ();

  size_class_block_allocator_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  scba_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_rx is set.
  always @(negedge clk) begin
    rsp.ready = !hold_rx && ($urandom_range(99) >= rx_stall_pct);
  end

  // Track granted blocks so that later requests name live addresses.
  always @(posedge clk) begin
    logic [OP_W-1:0] op;
    if (!rst) begin
      if (req.valid && req.ready) sent_ops.push_back(req.operation);
      if (rsp.valid && rsp.ready && sent_ops.size() != 0) begin
        op = sent_ops.pop_front();
        if ((op == OP_ALLOC || op == OP_REALLOC) && rsp.status == ST_NEW)
          live_blocks.push_back(rsp.block_address);
      end
    end
  end

  task automatic send(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] sz,
                      input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.operation = op;
    req.size_bytes = sz;
    req.address = addr;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    req.valid = 1'b0;
    sent++;
  endtask

  task automatic write_enable(input logic v);
    cfg.valid = 1'b1;
    cfg.heap_enable = v;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Let every expected result arrive.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return $urandom();
    if (r < 10) return $urandom_range(2049, 9000);
    if (r < 60) return $urandom_range(0, 128);
    return $urandom_range(0, MAX_BLOCK_BYTES);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int idx;
    if (live_blocks.size() != 0 && $urandom_range(99) < 80) begin
      idx = $urandom_range(live_blocks.size() - 1);
      pick_addr = live_blocks[idx];
      live_blocks.delete(idx);
    end else if ($urandom_range(1)) pick_addr = ADDR_W'($urandom_range(HEAP_SPAN - 1));
    else pick_addr = ADDR_W'($urandom());
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 40) send(OP_ALLOC, pick_size(), ADDR_W'($urandom()));
    else if (r < 65) send(OP_FREE, $urandom(), pick_addr());
    else if (r < 85) send(OP_REALLOC, pick_size(), pick_addr());
    else send(OP_SIZE, $urandom(), pick_addr());
  endtask

  // Stimulus.
  initial begin
    rst = 1'b1;
    hold_rx = 1'b0;
    sent = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    req.valid = 1'b0;
    req.operation = OP_ALLOC;
    req.size_bytes = '0;
    req.address = '0;
    cfg.valid = 1'b0;
    cfg.heap_enable = 1'b1;
    rsp.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners: zero and boundary sizes, class 41 filled to exhaustion.
    send(OP_ALLOC, 0, 0);
    send(OP_ALLOC, 1, 0);
    send(OP_ALLOC, 8, 0);
    send(OP_ALLOC, 9, 0);
    send(OP_ALLOC, 2049, 0);
    send(OP_ALLOC, 32'hFFFF_FFFF, 20'hFFFFF);
    repeat (9) send(OP_ALLOC, MAX_BLOCK_BYTES, 0);
    send(OP_SIZE, 0, 20'd16384);
    // Moving reallocate, kept reallocate, and both fallbacks.
    send(OP_REALLOC, 1500, 20'd671744);
    send(OP_REALLOC, 5, 20'd0);
    send(OP_REALLOC, 4000, 20'd8);
    send(OP_REALLOC, MAX_BLOCK_BYTES, 20'd16);
    send(OP_REALLOC, 2047, 20'd16384);
    // Interior free, addresses beyond the heap, list pop, double free.
    send(OP_FREE, 0, 20'd20);
    send(OP_FREE, 0, 20'(HEAP_SPAN));
    send(OP_SIZE, 0, 20'hFFFFF);
    send(OP_ALLOC, 4, 0);
    send(OP_FREE, 0, 20'd16384);
    drain();

    // Heap disabled: nothing is small and nothing is owned.
    write_enable(1'b0);
    repeat (12) random_item();
    drain();
    write_enable(1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 46 : 0;
      rx_stall_pct = (phase == 0) ? 46 : (phase == 1) ? 14 : 0;
      if (phase == 2) begin
        // Long receiver hold-off so the block backs up into its input.
        fork
          begin
            hold_rx = 1'b1;
            repeat (200) @(negedge clk);
            hold_rx = 1'b0;
          end
        join_none
      end
      repeat (RANDOM_PER_PHASE) random_item();
      drain();
      write_enable(phase != 1);
    end

    drain();
    $display("Covered %0d request items: corner sizes, exhaustion, reallocate paths,",
             sent);
    $display("disabled heap, and three idling mixes with a long receiver hold-off.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
